// File: rtl/core/x86_bit_manipulation_unit_top_defines.svh
// ---------------------------------------------------------------------------
// x86 bit-manipulation unit assertion macros
// Shared concurrent assertion forms for the execute unit.
// ---------------------------------------------------------------------------
`ifndef X86_BIT_MANIPULATION_UNIT_TOP_DEFINES_SVH
`define X86_BIT_MANIPULATION_UNIT_TOP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define XBMU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("xbmu: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define XBMU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("xbmu: same-cycle check failed");

`endif

// File: rtl/core/xbmu_pkg.sv
// ---------------------------------------------------------------------------
// xbmu_pkg
// Operation codes, flag positions and transaction types of the unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package xbmu_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned FlagsW = 12;
  localparam int unsigned FuncW  = 4;
  localparam int unsigned PopW   = 7;
  localparam int unsigned ZcntW  = 6;

  localparam int unsigned FlCf = 0;
  localparam int unsigned FlPf = 2;
  localparam int unsigned FlAf = 4;
  localparam int unsigned FlZf = 6;
  localparam int unsigned FlSf = 7;
  localparam int unsigned FlOf = 11;

  typedef enum logic [FuncW-1:0] {
    FN_POPCNT = 4'd0,
    FN_MOVBE  = 4'd1,
    FN_LZCNT  = 4'd2,
    FN_TZCNT  = 4'd3,
    FN_ANDN   = 4'd4,
    FN_BLSI   = 4'd5,
    FN_BLSMSK = 4'd6,
    FN_BLSR   = 4'd7
  } func_t;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic              narrow16;
    logic [DataW-1:0]  dest_value;
    logic [DataW-1:0]  source_value;
    logic [FlagsW-1:0] flags_in;
  } op_t;

  typedef struct packed {
    logic [DataW-1:0]  result_value;
    logic [FlagsW-1:0] flags_out;
    logic              unrecognized;
  } res_t;

endpackage

// File: rtl/core/xbmu_cnt.sv
// ---------------------------------------------------------------------------
// xbmu_cnt
// Population count over 64 bits and leading or trailing zero count over
// the low 16 or 32 source bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xbmu_cnt (
  input  logic [xbmu_pkg::DataW-1:0] src,
  input  logic                       narrow16,
  input  logic                       lead,
  output logic [xbmu_pkg::PopW-1:0]  pop,
  output logic [xbmu_pkg::ZcntW-1:0] zcnt
);
  import xbmu_pkg::*;

  logic [1:0] l1 [32];
  logic [2:0] l2 [16];
  logic [3:0] l3 [8];
  logic [4:0] l4 [4];
  logic [5:0] l5 [2];

  logic [31:0] part;
  logic [31:0] rev;
  logic [31:0] scan;
  logic [31:0] iso;
  logic [4:0]  enc;

  always_comb begin
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, src[2*i]} + {1'b0, src[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    pop = {1'b0, l5[0]} + {1'b0, l5[1]};
  end

  always_comb begin
    part = narrow16 ? {16'h0000, src[15:0]} : src[31:0];
    rev  = '0;
    if (narrow16) begin
      for (int i = 0; i < 16; i++) rev[i] = src[15-i];
    end else begin
      for (int i = 0; i < 32; i++) rev[i] = src[31-i];
    end
    scan = lead ? rev : part;
    iso  = scan & (~scan + 32'd1);
    enc  = '0;
    for (int i = 0; i < 32; i++) begin
      if (iso[i]) enc = enc | 5'(i);
    end
    if (scan == 32'd0) begin
      zcnt = narrow16 ? 6'd16 : 6'd32;
    end else begin
      zcnt = {1'b0, enc};
    end
  end

endmodule

// File: rtl/core/xbmu_exec.sv
// ---------------------------------------------------------------------------
// xbmu_exec
// Result and flag selection for one registered operation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xbmu_exec (
  input  xbmu_pkg::op_t  op,
  output xbmu_pkg::res_t res
);
  import xbmu_pkg::*;

  logic [DataW-1:0]  src;
  logic [DataW-1:0]  dst;
  logic [DataW-1:0]  neg;
  logic [DataW-1:0]  dec;
  logic [DataW-1:0]  lres;
  logic [FlagsW-1:0] fl;
  logic [PopW-1:0]   pop;
  logic [ZcntW-1:0]  zcnt;
  logic              src_zero;

  assign src      = op.source_value;
  assign dst      = op.dest_value;
  assign neg      = ~src + 64'd1;
  assign dec      = src - 64'd1;
  assign src_zero = (src == 64'd0);

  xbmu_cnt u_cnt (
    .src      (src),
    .narrow16 (op.narrow16),
    .lead     (op.func == FN_LZCNT),
    .pop      (pop),
    .zcnt     (zcnt)
  );

  always_comb begin
    fl               = op.flags_in;
    lres             = '0;
    res.result_value = dst;
    res.unrecognized = 1'b0;
    case (op.func)
      FN_POPCNT: begin
        res.result_value = {{(DataW-PopW){1'b0}}, pop};
        fl[FlOf] = 1'b0;
        fl[FlSf] = 1'b0;
        fl[FlAf] = 1'b0;
        fl[FlCf] = 1'b0;
        fl[FlPf] = 1'b0;
        fl[FlZf] = src_zero;
      end
      FN_MOVBE: begin
        if (op.narrow16) begin
          res.result_value = {dst[63:16], src[7:0], src[15:8]};
        end else begin
          res.result_value = {32'h0, src[7:0], src[15:8], src[23:16], src[31:24]};
        end
      end
      FN_LZCNT, FN_TZCNT: begin
        if (op.narrow16) begin
          res.result_value = {dst[63:16], 10'h000, zcnt};
        end else begin
          res.result_value = {{(DataW-ZcntW){1'b0}}, zcnt};
        end
        fl[FlCf] = op.narrow16 ? (zcnt == 6'd16) : (zcnt == 6'd32);
        fl[FlZf] = (zcnt == 6'd0);
      end
      FN_ANDN, FN_BLSI, FN_BLSMSK, FN_BLSR: begin
        case (op.func)
          FN_ANDN: lres = ~dst & src;
          FN_BLSI: lres = src & neg;
          FN_BLSMSK: lres = src ^ dec;
          default: lres = src & dec;
        endcase
        res.result_value = lres;
        fl[FlOf] = 1'b0;
        fl[FlSf] = lres[DataW-1];
        fl[FlZf] = (op.func == FN_BLSMSK) ? 1'b0 : (lres == 64'd0);
        case (op.func)
          FN_ANDN: fl[FlCf] = 1'b0;
          FN_BLSI: fl[FlCf] = !src_zero;
          default: fl[FlCf] = src_zero;
        endcase
      end
      default: begin
        res.unrecognized = 1'b1;
      end
    endcase
    res.flags_out = fl;
  end

endmodule

// File: rtl/core/x86_bit_manipulation_unit_top.sv
// ---------------------------------------------------------------------------
// x86_bit_manipulation_unit_top
// Execute unit for POPCNT, MOVBE, LZCNT, TZCNT, ANDN, BLSI, BLSMSK and BLSR.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_ready   func, narrow16, dest, source, flags
//   out_      output     out_valid / out_ready result_value, flags_out, unrecognized
//
// One transaction is accepted per cycle while the result is not stalled; it
// passes through the input register and then the result register, with a
// single pass of count, swap and logic operations between them.
// Reset clears both valid bits; payload registers are not reset.
// While out_ready is low the result holds, and in_ready falls once the
// input register is also full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "x86_bit_manipulation_unit_top_defines.svh"

module x86_bit_manipulation_unit_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [xbmu_pkg::FuncW-1:0]  in_func,
  input  logic                        in_narrow16,
  input  logic [xbmu_pkg::DataW-1:0]  in_dest_value,
  input  logic [xbmu_pkg::DataW-1:0]  in_source_value,
  input  logic [xbmu_pkg::FlagsW-1:0] in_flags_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [xbmu_pkg::DataW-1:0]  out_result_value,
  output logic [xbmu_pkg::FlagsW-1:0] out_flags_out,
  output logic                        out_unrecognized
);
  import xbmu_pkg::*;

  op_t  op_r;
  op_t  op_nxt;
  logic op_valid_r;
  res_t res_r;
  res_t res_nxt;
  logic res_valid_r;
  logic res_load;
  logic in_load;

  assign res_load = op_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !op_valid_r || res_load;
  assign in_load  = in_valid && in_ready;

  assign op_nxt.func         = in_func;
  assign op_nxt.narrow16     = in_narrow16;
  assign op_nxt.dest_value   = in_dest_value;
  assign op_nxt.source_value = in_source_value;
  assign op_nxt.flags_in     = in_flags_in;

  xbmu_exec u_exec (
    .op  (op_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else if (in_ready) begin
      op_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      op_r <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_load) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_result_value = res_r.result_value;
  assign out_flags_out    = res_r.flags_out;
  assign out_unrecognized = res_r.unrecognized;

  `XBMU_ASSERT_NEXT(a_op_kept, clk, rst_n, op_valid_r && !res_load, op_valid_r)
  `XBMU_ASSERT_NEXT(a_res_loaded, clk, rst_n, res_load, res_valid_r)
  `XBMU_ASSERT_NEXT(a_pop_range, clk, rst_n, res_load && (op_r.func == FN_POPCNT),
                    !out_unrecognized && (out_result_value <= 64'd64))
  `XBMU_ASSERT_NEXT(a_bad_passes, clk, rst_n, res_load && op_r.func[FuncW-1],
                    out_unrecognized && (out_result_value == $past(op_r.dest_value)))

endmodule

// File: bench/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for x86_bit_manipulation_unit_top
// A directed table of transactions covers the operand extremes, every
// operation code, both operand sizes, unrecognized codes 8 and 15 and the
// pass-through of the high flag bits. A random stream follows it. Results
// are checked field by field against an in-order queue of predictions,
// while the sender works in bursts and the receiver stalls on patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import xbmu_pkg::*;

  localparam int unsigned RANDOM_OPS     = 700;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned N_DIRECTED     = 24;

  localparam logic [FuncW-1:0] FN_RSVD_LO = 4'd8;
  localparam logic [FuncW-1:0] FN_RSVD_HI = 4'd15;

  localparam logic [FlagsW-1:0] CF_BIT = FlagsW'(1) << FlCf;
  localparam logic [FlagsW-1:0] PF_BIT = FlagsW'(1) << FlPf;
  localparam logic [FlagsW-1:0] AF_BIT = FlagsW'(1) << FlAf;
  localparam logic [FlagsW-1:0] ZF_BIT = FlagsW'(1) << FlZf;
  localparam logic [FlagsW-1:0] SF_BIT = FlagsW'(1) << FlSf;
  localparam logic [FlagsW-1:0] OF_BIT = FlagsW'(1) << FlOf;

  localparam logic [DataW-1:0] ONES = {DataW{1'b1}};

  typedef struct packed {
    logic [DataW-1:0]  value;
    logic [FlagsW-1:0] flags;
    logic              unrec;
  } bit_op_result_t;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic              narrow16;
    logic [DataW-1:0]  dest;
    logic [DataW-1:0]  source;
    logic [FlagsW-1:0] flags;
    logic              typed;
    logic [DataW-1:0]  want_value;
    logic [FlagsW-1:0] want_flags;
    logic              want_unrec;
  } directed_op_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FuncW-1:0]  in_func = '0;
  logic              in_narrow16 = 1'b0;
  logic [DataW-1:0]  in_dest_value = '0;
  logic [DataW-1:0]  in_source_value = '0;
  logic [FlagsW-1:0] in_flags_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DataW-1:0]  out_result_value;
  logic [FlagsW-1:0] out_flags_out;
  logic              out_unrecognized;

  logic           typed_valid = 1'b0;
  bit_op_result_t typed_result = '0;

  bit_op_result_t pending_results[$];
  bit_op_result_t oldest, observed;
  directed_op_t   directed_ops [N_DIRECTED];

  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned unrec_results = 0;
  int unsigned ops_issued = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_phase = 0;

  x86_bit_manipulation_unit_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_narrow16      (in_narrow16),
    .in_dest_value    (in_dest_value),
    .in_source_value  (in_source_value),
    .in_flags_in      (in_flags_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_flags_out    (out_flags_out),
    .out_unrecognized (out_unrecognized)
  );

  always #1 clk = ~clk;

  function automatic logic [FlagsW-1:0] logic_op_flags(input logic [FlagsW-1:0] fl,
                                                       input logic [DataW-1:0] res,
                                                       input logic cf, input logic zf_en);
    logic [FlagsW-1:0] f;
    f = fl & ~(CF_BIT | ZF_BIT | SF_BIT | OF_BIT);
    if (cf) f = f | CF_BIT;
    if (zf_en && res == '0) f = f | ZF_BIT;
    if (res[DataW-1]) f = f | SF_BIT;
    return f;
  endfunction

  function automatic bit_op_result_t exec_bit_op(input logic [FuncW-1:0] func,
                                                 input logic narrow,
                                                 input logic [DataW-1:0] dst,
                                                 input logic [DataW-1:0] src,
                                                 input logic [FlagsW-1:0] fl);
    bit_op_result_t r;
    logic [DataW-1:0] part;
    logic [DataW-1:0] cnt;
    logic found;
    int i;
    int width;
    r.value = dst;
    r.flags = fl;
    r.unrec = 1'b0;
    width = narrow ? 16 : 32;
    part = narrow ? {48'd0, src[15:0]} : {32'd0, src[31:0]};
    cnt = '0;
    found = 1'b0;
    case (func)
      FN_POPCNT: begin
        for (i = 0; i < DataW; i++) cnt = cnt + DataW'(src[i]);
        r.value = cnt;
        r.flags = fl & ~(OF_BIT | SF_BIT | ZF_BIT | AF_BIT | CF_BIT | PF_BIT);
        if (src == '0) r.flags = r.flags | ZF_BIT;
      end
      FN_MOVBE: begin
        if (narrow) r.value = {dst[63:16], src[7:0], src[15:8]};
        else r.value = {32'd0, src[7:0], src[15:8], src[23:16], src[31:24]};
      end
      FN_LZCNT, FN_TZCNT: begin
        if (func == FN_LZCNT) begin
          for (i = width - 1; i >= 0; i--) begin
            if (!found) begin
              if (part[i]) found = 1'b1;
              else cnt = cnt + 64'd1;
            end
          end
        end else begin
          for (i = 0; i < width; i++) begin
            if (!found) begin
              if (part[i]) found = 1'b1;
              else cnt = cnt + 64'd1;
            end
          end
        end
        r.value = narrow ? {dst[63:16], cnt[15:0]} : cnt;
        r.flags = fl & ~(CF_BIT | ZF_BIT);
        if (part == '0) r.flags = r.flags | CF_BIT;
        if (cnt == '0) r.flags = r.flags | ZF_BIT;
      end
      FN_ANDN: begin
        r.value = ~dst & src;
        r.flags = logic_op_flags(fl, r.value, 1'b0, 1'b1);
      end
      FN_BLSI: begin
        r.value = src & (~src + 64'd1);
        r.flags = logic_op_flags(fl, r.value, src != '0, 1'b1);
      end
      FN_BLSMSK: begin
        r.value = src ^ (src - 64'd1);
        r.flags = logic_op_flags(fl, r.value, src == '0, 1'b0);
      end
      FN_BLSR: begin
        r.value = src & (src - 64'd1);
        r.flags = logic_op_flags(fl, r.value, src == '0, 1'b1);
      end
      default: begin
        r.unrec = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic logic [DataW-1:0] pick_operand();
    logic [DataW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = ONES;
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = {48'd0, v[15:0]};
      4: v = {v[63:16], 16'd0};
      5: v = {v[63:32], 32'd0};
      6: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic issue_op(input logic [FuncW-1:0] func, input logic narrow,
                          input logic [DataW-1:0] dst, input logic [DataW-1:0] src,
                          input logic [FlagsW-1:0] fl, input logic typed,
                          input bit_op_result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_func         <= func;
    in_narrow16     <= narrow;
    in_dest_value   <= dst;
    in_source_value <= src;
    in_flags_in     <= fl;
    typed_valid     <= typed;
    typed_result    <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ops_issued++;
  endtask

  task automatic note_mismatch(input string what, input bit_op_result_t want,
                               input bit_op_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s: expected value %h flags %h unrec %b, got value %h flags %h unrec %b",
               $time, what, want.value, want.flags, want.unrec,
               got.value, got.flags, got.unrec);
  endtask

  // Receiver: stall pattern changes every stretch of cycles.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(40, 120);
      stall_mode = $urandom_range(0, 3);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_phase % 4) != 0;
      default: out_ready <= (stall_phase % 16) == 0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        observed.value = out_result_value;
        observed.flags = out_flags_out;
        observed.unrec = out_unrecognized;
        results_checked++;
        if (out_unrecognized) unrec_results++;
        if (pending_results.size() == 0) begin
          note_mismatch("result with no transaction pending", '0, observed);
        end else begin
          oldest = pending_results.pop_front();
          if (observed.value !== oldest.value || observed.flags !== oldest.flags ||
              observed.unrec !== oldest.unrec)
            note_mismatch("result mismatch", oldest, observed);
        end
      end
      if (in_valid && in_ready) begin
        if (typed_valid) pending_results.push_back(typed_result);
        else pending_results.push_back(exec_bit_op(in_func, in_narrow16, in_dest_value,
                                                   in_source_value, in_flags_in));
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Watchdog expired with %0d results outstanding.", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    bit_op_result_t want;
    logic [FuncW-1:0] func;
    directed_ops = '{
      '{FN_POPCNT, 1'b0, 64'h0, 64'h0, 12'hFFF, 1'b1, 64'h0, 12'h76A, 1'b0},
      '{FN_POPCNT, 1'b1, 64'h0123_4567_89AB_CDEF, ONES, 12'h000, 1'b1, 64'd64, 12'h000, 1'b0},
      '{FN_MOVBE, 1'b1, 64'h1111_2222_3333_4444, 64'hAAAA_BBBB_CCCC_1234, 12'h5A5,
        1'b1, 64'h1111_2222_3333_3412, 12'h5A5, 1'b0},
      '{FN_MOVBE, 1'b0, ONES, 64'hFFFF_FFFF_1234_5678, 12'h0F0,
        1'b1, 64'h0000_0000_7856_3412, 12'h0F0, 1'b0},
      '{FN_LZCNT, 1'b0, ONES, 64'h0, 12'h000, 1'b1, 64'd32, 12'h001, 1'b0},
      '{FN_LZCNT, 1'b1, ONES, 64'hFFFF_FFFF_FFFF_0000, 12'h040,
        1'b1, 64'hFFFF_FFFF_FFFF_0010, 12'h001, 1'b0},
      '{FN_LZCNT, 1'b0, ONES, 64'h0000_0000_8000_0000, 12'h000, 1'b1, 64'h0, 12'h040, 1'b0},
      '{FN_TZCNT, 1'b0, 64'h0, 64'h0, 12'hFFF, 1'b1, 64'd32, 12'hFBF, 1'b0},
      '{FN_TZCNT, 1'b1, 64'h0, 64'h1, 12'h000, 1'b1, 64'h0, 12'h040, 1'b0},
      '{FN_TZCNT, 1'b0, ONES, 64'h0000_0000_8000_0000, 12'h5A5, 1'b0, 64'h0, 12'h0, 1'b0},
      '{FN_ANDN, 1'b0, 64'h0, ONES, 12'h000, 1'b1, ONES, 12'h080, 1'b0},
      '{FN_ANDN, 1'b0, ONES, ONES, 12'hFFF, 1'b1, 64'h0, 12'h77E, 1'b0},
      '{FN_BLSI, 1'b0, ONES, 64'h0, 12'h000, 1'b1, 64'h0, 12'h040, 1'b0},
      '{FN_BLSI, 1'b0, 64'h0, 64'h8000_0000_0000_0000, 12'h000,
        1'b1, 64'h8000_0000_0000_0000, 12'h081, 1'b0},
      '{FN_BLSMSK, 1'b0, 64'h0, 64'h0, 12'h000, 1'b1, ONES, 12'h081, 1'b0},
      '{FN_BLSMSK, 1'b0, 64'h0, ONES, 12'hFFF, 1'b1, 64'h1, 12'h73E, 1'b0},
      '{FN_BLSR, 1'b0, ONES, 64'h0, 12'h000, 1'b1, 64'h0, 12'h041, 1'b0},
      '{FN_BLSR, 1'b0, ONES, 64'h8000_0000_0000_0000, 12'h000, 1'b1, 64'h0, 12'h040, 1'b0},
      '{FN_BLSR, 1'b1, 64'h0, 64'hDEAD_BEEF_0BAD_F00D, 12'hA5A, 1'b0, 64'h0, 12'h0, 1'b0},
      '{FN_RSVD_LO, 1'b0, 64'hCAFE_F00D_1234_5678, ONES, 12'hABC,
        1'b1, 64'hCAFE_F00D_1234_5678, 12'hABC, 1'b1},
      '{FN_RSVD_HI, 1'b1, ONES, 64'h0, 12'hFFF, 1'b1, ONES, 12'hFFF, 1'b1},
      '{FN_POPCNT, 1'b1, ONES, 64'h0F0F_0F0F_0F0F_0F0F, 12'hFFF, 1'b0, 64'h0, 12'h0, 1'b0},
      '{FN_ANDN, 1'b1, 64'h00FF_00FF_00FF_00FF, ONES, 12'h800, 1'b0, 64'h0, 12'h0, 1'b0},
      '{FN_MOVBE, 1'b1, 64'h0, ONES, 12'hFFF, 1'b0, 64'h0, 12'h0, 1'b0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++) begin
      want.value = directed_ops[k].want_value;
      want.flags = directed_ops[k].want_flags;
      want.unrec = directed_ops[k].want_unrec;
      issue_op(directed_ops[k].func, directed_ops[k].narrow16, directed_ops[k].dest,
               directed_ops[k].source, directed_ops[k].flags, directed_ops[k].typed, want);
    end

    for (int k = 0; k < RANDOM_OPS; k++) begin
      if ($urandom_range(0, 9) == 0) func = FuncW'($urandom_range(FN_RSVD_LO, FN_RSVD_HI));
      else func = FuncW'($urandom_range(FN_POPCNT, FN_BLSR));
      issue_op(func, 1'($urandom_range(0, 1)), pick_operand(), pick_operand(),
               FlagsW'($urandom_range(0, 4095)), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions (%0d directed), %0d results checked.",
             ops_issued, N_DIRECTED, results_checked);
    $display("Unrecognized operation results: %0d, mismatches: %0d.",
             unrec_results, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
